@@ rtl/penum_pkg.sv @@
package penum_pkg;

    localparam int ELEM_W = 32;
    localparam int POS_W  = 3;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIVOT,
        S_SWAP,
        S_SORT,
        S_CHECK,
        S_EMIT,
        S_STAT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              append;
        logic              clear_count;
        logic              restart;
        logic              latch_pivot;
        logic              do_swap;
        logic              sort_step;
        logic              cnt_clear;
        logic              cnt_inc;
        logic              emit_perm;
        logic              emit_status;
        logic              final_perm;
        logic [STAT_W-1:0] code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic has_pivot;
        logic sort_done;
        logic at_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/permutation_enumerator.sv @@
// load and clear give no result; a status item goes through S_STAT and then the
// output register, and waits there while the output register still holds an item
// next permutation: steps in order are pivot, swap, tail sort and check, then one
// element per cycle while the output register is free
// the first permutation after a load or clear skips pivot, swap and sort
// reset (i_rst_n low, synchronous): list empty, order back to identity, no item out
module permutation_enumerator #(
    parameter int MAX_N = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [penum_pkg::ELEM_W-1:0]  i_s_tdata,   // value
    input  logic [penum_pkg::MODE_W-1:0]  i_s_tuser,   // mode
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [penum_pkg::ELEM_W-1:0]  o_m_tdata,   // element
    output logic                          o_m_tlast,   // last_in_run
    output logic [penum_pkg::STAT_W:0]    o_m_tuser    // final_permutation, status[1:0]
);
    import penum_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller: sequences load / clear / next and the swap-and-sort steps
    penum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: element store, position order lanes, step counter, output register
    penum_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_out_last  (o_m_tlast),
        .o_out_user  (o_m_tuser)
    );

    // never load the output register over an item that is still waiting
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_perm || cmd.emit_status) |-> sts.out_free)
        else $error("result loaded over a waiting item");

    // while taking input nothing of the permutation step is in flight
    a_idle_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !(cmd.emit_perm || cmd.do_swap || cmd.sort_step || cmd.latch_pivot))
        else $error("permutation work while accepting items");

    // at most one order-changing command per cycle
    a_one_order_op : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.restart, cmd.do_swap, cmd.sort_step}))
        else $error("conflicting order updates");

    // a swap always follows a pivot latch
    a_swap_after_pivot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.do_swap |-> $past(cmd.latch_pivot))
        else $error("swap without pivot");

endmodule

@@ rtl/penum_dp.sv @@
module penum_dp #(
    parameter int MAX_N = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  penum_pkg::t_cmd               i_cmd,
    output penum_pkg::t_sts               o_sts,
    input  logic [penum_pkg::ELEM_W-1:0]  i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [penum_pkg::ELEM_W-1:0]  o_out_data,
    output logic                          o_out_last,
    output logic [penum_pkg::STAT_W:0]    o_out_user
);
    import penum_pkg::*;

    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CNT_W = $clog2(MAX_N + 1);

    logic [ELEM_W-1:0] r_store [MAX_N];
    logic [POS_W-1:0]  r_ord   [MAX_N];
    logic [POS_W-1:0]  n_ord   [MAX_N];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_step;
    logic [IDX_W-1:0]  r_piv;
    logic [POS_W-1:0]  r_pv;

    logic [IDX_W-1:0]  piv_idx;
    logic              has_piv;
    logic [IDX_W-1:0]  j_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic [POS_W-1:0]  rd_data;

    logic              r_vld;
    logic [ELEM_W-1:0] r_data;
    logic              r_last;
    logic [STAT_W:0]   r_user;

    // rightmost ascent within the loaded part of the order
    always_comb begin
        piv_idx = '0;
        has_piv = 1'b0;
        for (int i = 0; i < MAX_N - 1; i++) begin
            if ((CNT_W'(i + 1) < r_count) && (r_ord[i] < r_ord[i + 1])) begin
                piv_idx = IDX_W'(i);
                has_piv = 1'b1;
            end
        end
    end

    // rightmost tail entry above the pivot value
    always_comb begin
        j_idx = '0;
        for (int i = 0; i < MAX_N; i++) begin
            if ((IDX_W'(i) > r_piv) && (CNT_W'(i) < r_count) && (r_ord[i] > r_pv))
                j_idx = IDX_W'(i);
        end
    end

    // single read port on the order
    always_comb begin
        if (i_cmd.latch_pivot) begin
            rd_addr = piv_idx;
        end else if (i_cmd.do_swap) begin
            rd_addr = j_idx;
        end else begin
            rd_addr = r_step[IDX_W-1:0];
        end
    end
    assign rd_data = r_ord[rd_addr];

    // order update: identity on restart; otherwise swap, then odd-even transposition over the tail
    always_comb begin
        n_ord = r_ord;
        if (i_cmd.restart) begin
            for (int i = 0; i < MAX_N; i++)
                n_ord[i] = POS_W'(i);
        end else if (i_cmd.do_swap) begin
            n_ord[r_piv] = rd_data;
            n_ord[j_idx] = r_pv;
        end else if (i_cmd.sort_step) begin
            for (int i = 0; i < MAX_N - 1; i++) begin
                if ((1'(i) == r_step[0]) && (IDX_W'(i) > r_piv) &&
                    (CNT_W'(i + 1) < r_count) && (r_ord[i] > r_ord[i + 1])) begin
                    n_ord[i]     = r_ord[i + 1];
                    n_ord[i + 1] = r_ord[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_N; i++)
                r_ord[i] <= POS_W'(i);
            r_count <= '0;
            r_step  <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_ord <= n_ord;
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.cnt_clear) begin
                r_step <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_step <= r_step + CNT_W'(1);
            end
            if (i_cmd.emit_perm || i_cmd.emit_status) begin
                r_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append)
            r_store[r_count[IDX_W-1:0]] <= i_value;
        if (i_cmd.latch_pivot) begin
            r_piv <= piv_idx;
            r_pv  <= rd_data;
        end
        if (i_cmd.emit_perm) begin
            r_data <= r_store[rd_data[IDX_W-1:0]];
            r_last <= o_sts.at_last;
            r_user <= {ST_OK, i_cmd.final_perm};
        end else if (i_cmd.emit_status) begin
            r_data <= '0;
            r_last <= 1'b1;
            r_user <= {i_cmd.code, 1'b0};
        end
    end

    assign o_sts.full      = (r_count == CNT_W'(MAX_N));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.has_pivot = has_piv;
    assign o_sts.sort_done = (r_step == CNT_W'(MAX_N - 1));
    assign o_sts.at_last   = ((r_step + CNT_W'(1)) == r_count);
    assign o_sts.out_free  = !r_vld || i_out_ready;

    assign o_out_valid = r_vld;
    assign o_out_data  = r_data;
    assign o_out_last  = r_last;
    assign o_out_user  = r_user;

endmodule

@@ rtl/penum_ctrl.sv @@
module penum_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [penum_pkg::MODE_W-1:0]  i_mode,
    output logic                          o_in_ready,
    input  penum_pkg::t_sts               i_sts,
    output penum_pkg::t_cmd               o_cmd
);
    import penum_pkg::*;

    t_state            r_state, n_state;
    logic              r_started, n_started;
    logic              r_exhausted, n_exhausted;
    logic              r_final, n_final;
    logic [STAT_W-1:0] r_code, n_code;
    logic              accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // next state and flags
    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_exhausted = r_exhausted;
        n_final     = r_final;
        n_code      = r_code;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_LOAD: begin
                            if (i_sts.full) begin
                                n_code  = ST_OVERFLOW;
                                n_state = S_STAT;
                            end else begin
                                n_started   = 1'b0;
                                n_exhausted = 1'b0;
                            end
                        end
                        MODE_CLEAR: begin
                            n_started   = 1'b0;
                            n_exhausted = 1'b0;
                        end
                        MODE_NEXT: begin
                            if (i_sts.empty || r_exhausted) begin
                                n_code  = ST_EMPTY;
                                n_state = S_STAT;
                            end else if (r_started) begin
                                n_state = S_PIVOT;
                            end else begin
                                n_state = S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PIVOT: begin
                if (!i_sts.has_pivot) begin
                    n_exhausted = 1'b1;
                    n_code      = ST_EMPTY;
                    n_state     = S_STAT;
                end else begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: n_state = S_SORT;
            S_SORT: begin
                if (i_sts.sort_done)
                    n_state = S_CHECK;
            end
            S_CHECK: begin
                n_started = 1'b1;
                n_final   = !i_sts.has_pivot;
                if (!i_sts.has_pivot)
                    n_exhausted = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.at_last)
                    n_state = S_IDLE;
            end
            S_STAT: begin
                if (i_sts.out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_cmd.final_perm = r_final;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_LOAD: begin
                            if (!i_sts.full) begin
                                o_cmd.append  = 1'b1;
                                o_cmd.restart = 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            o_cmd.clear_count = 1'b1;
                            o_cmd.restart     = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_PIVOT: o_cmd.latch_pivot = i_sts.has_pivot;
            S_SWAP: begin
                o_cmd.do_swap   = 1'b1;
                o_cmd.cnt_clear = 1'b1;
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
            end
            S_CHECK: o_cmd.cnt_clear = 1'b1;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_perm = 1'b1;
                    o_cmd.cnt_inc   = 1'b1;
                end
            end
            S_STAT: o_cmd.emit_status = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_exhausted <= 1'b0;
            r_final     <= 1'b0;
            r_code      <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_exhausted <= n_exhausted;
            r_final     <= n_final;
            r_code      <= n_code;
        end
    end

endmodule

@@ test/tb_permutation_enumerator.sv @@
`timescale 1ns / 100ps

module tb_permutation_enumerator;
    import penum_pkg::*;

    localparam int N_MAX = 8;
    // the one mode code the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // one result item as the block presents it
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              is_last;
        logic              final_perm;
        logic [STAT_W-1:0] status;
    } t_beat;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [ELEM_W-1:0] i_s_tdata  = '0;   // value
    logic [MODE_W-1:0] i_s_tuser  = '0;   // mode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [ELEM_W-1:0] o_m_tdata;         // element
    logic              o_m_tlast;         // last_in_run
    logic [STAT_W:0]   o_m_tuser;         // final_permutation, status[1:0]

    // idle chances in percent, changed between phases
    int send_idle_pct = 30;
    int recv_idle_pct = 68;
    int err_count     = 0;

    // shadow of the block state
    logic [ELEM_W-1:0] shadow_vals  [N_MAX];
    logic [POS_W-1:0]  shadow_order [N_MAX];
    int                shadow_count;
    bit                shadow_started;
    bit                shadow_done;

    // result items still owed by the block, oldest first
    t_beat pending_beats[$];

    permutation_enumerator #(
        .MAX_N(N_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // permutation predictor
    // ---------------------------------------------------------------

    // back to the load order: identity positions, nothing emitted yet
    task automatic restart_shadow();
        for (int i = 0; i < N_MAX; i++) begin
            shadow_order[i] = POS_W'(i);
        end
        shadow_started = 1'b0;
        shadow_done    = 1'b0;
    endtask

    // rightmost position that is smaller than its right neighbor, -1 if none
    function automatic int pivot_of();
        for (int i = shadow_count - 2; i >= 0; i--) begin
            if (shadow_order[i] < shadow_order[i + 1]) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic push_status(input logic [STAT_W-1:0] code);
        t_beat b;
        b.element    = '0;
        b.is_last    = 1'b1;
        b.final_perm = 1'b0;
        b.status     = code;
        pending_beats = {pending_beats, b};
    endtask

    // apply one accepted item to the shadow and queue what it produces
    task automatic enumerate_step(input logic [MODE_W-1:0] mode, input logic [ELEM_W-1:0] value);
        int               p;
        int               j;
        int               lo;
        int               hi;
        bit               at_end;
        bit               ran_out;
        logic [POS_W-1:0] t;
        t_beat            b;
        case (mode)
            MODE_LOAD: begin
                if (shadow_count >= N_MAX) begin
                    // full list: value dropped, enumeration untouched
                    push_status(ST_OVERFLOW);
                end else begin
                    shadow_vals[shadow_count] = value;
                    shadow_count++;
                    restart_shadow();
                end
            end
            MODE_CLEAR: begin
                shadow_count = 0;
                restart_shadow();
            end
            MODE_NEXT: begin
                if (shadow_count == 0 || shadow_done) begin
                    push_status(ST_EMPTY);
                end else begin
                    ran_out = 1'b0;
                    if (shadow_started) begin
                        p = pivot_of();
                        if (p < 0) begin
                            shadow_done = 1'b1;
                            ran_out     = 1'b1;
                            push_status(ST_EMPTY);
                        end else begin
                            // swap pivot with the rightmost larger tail entry, then reverse the tail
                            j = shadow_count - 1;
                            while (shadow_order[j] <= shadow_order[p]) begin
                                j--;
                            end
                            t               = shadow_order[p];
                            shadow_order[p] = shadow_order[j];
                            shadow_order[j] = t;
                            lo = p + 1;
                            hi = shadow_count - 1;
                            while (lo < hi) begin
                                t                = shadow_order[lo];
                                shadow_order[lo] = shadow_order[hi];
                                shadow_order[hi] = t;
                                lo++;
                                hi--;
                            end
                        end
                    end
                    if (!ran_out) begin
                        shadow_started = 1'b1;
                        at_end = (pivot_of() < 0);
                        if (at_end) begin
                            shadow_done = 1'b1;
                        end
                        for (int k = 0; k < shadow_count; k++) begin
                            b.element    = shadow_vals[shadow_order[k]];
                            b.is_last    = (k + 1 == shadow_count);
                            b.final_perm = at_end;
                            b.status     = ST_OK;
                            pending_beats = {pending_beats, b};
                        end
                    end
                end
            end
            default: begin
                // spare mode: ignored
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [ELEM_W-1:0] got,
                                   input logic [ELEM_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        err_count++;
    endtask

    // compares each taken result item with the oldest owed one and
    // redraws the receiver stall for the next cycle
    always @(posedge i_clk) begin : result_check
        t_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected item", o_m_tdata, '0);
            end else begin
                want = pending_beats.pop_front();
                if (o_m_tdata !== want.element) begin
                    report_mismatch("element", o_m_tdata, want.element);
                end
                if (o_m_tlast !== want.is_last) begin
                    report_mismatch("last_in_run", ELEM_W'(o_m_tlast), ELEM_W'(want.is_last));
                end
                if (o_m_tuser[0] !== want.final_perm) begin
                    report_mismatch("final_permutation", ELEM_W'(o_m_tuser[0]),
                                    ELEM_W'(want.final_perm));
                end
                if (o_m_tuser[STAT_W:1] !== want.status) begin
                    report_mismatch("status", ELEM_W'(o_m_tuser[STAT_W:1]), ELEM_W'(want.status));
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // offer one item, wait for the handshake, then predict it
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ELEM_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        enumerate_step(mode, value);
    endtask

    // hold the input quiet until every owed result item has come out
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // extremes show up often, the rest is random
    function automatic logic [ELEM_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // next on an empty list, spare mode, clear on an empty list
    task automatic test_empty_list();
        send_item(MODE_NEXT, 32'hffff_ffff);
        send_item(MODE_SPARE, 32'hffff_ffff);
        send_item(MODE_CLEAR, 32'h0000_0000);
    endtask

    // one element: its only permutation is also the final one, then exhausted
    task automatic test_single_element();
        send_item(MODE_CLEAR, 32'h0000_0000);
        send_item(MODE_LOAD, 32'h8000_0000);
        send_item(MODE_NEXT, 32'h0000_0000);
        send_item(MODE_NEXT, 32'h0000_0000);
    endtask

    // three elements: all six orders, then one exhausted status
    task automatic test_three_elements();
        send_item(MODE_CLEAR, 32'h0000_0000);
        send_item(MODE_LOAD, 32'h7fff_ffff);
        send_item(MODE_LOAD, 32'hffff_ffff);
        send_item(MODE_LOAD, 32'h0000_0000);
        repeat (7) begin
            send_item(MODE_NEXT, 32'h0000_0000);
        end
    endtask

    // fill up to the limit on top of the three, overflow once, then next
    task automatic test_full_list();
        send_item(MODE_LOAD, 32'h0000_0001);
        send_item(MODE_LOAD, 32'h8000_0000);
        send_item(MODE_LOAD, 32'h5a5a_5a5a);
        send_item(MODE_LOAD, 32'ha5a5_a5a5);
        send_item(MODE_LOAD, 32'h7fff_fffe);
        send_item(MODE_LOAD, 32'h1234_5678);
        send_item(MODE_NEXT, 32'hffff_ffff);
    endtask

    // mostly clean runs: clear, load a few, step through the orders;
    // sprinkled with spare modes, loads and clears in mid run, overflows
    task automatic test_random(input int items);
        int sent;
        int n;
        int runs;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            if ($urandom_range(0, 9) != 0) begin
                send_item(MODE_CLEAR, pick_value());
                sent++;
            end
            repeat (n) begin
                send_item(MODE_LOAD, pick_value());
                sent++;
            end
            if (n <= 4) begin
                // small sets usually run to the end and a little past it
                runs = ((n == 1) ? 1 : (n == 2) ? 2 : (n == 3) ? 6 : 24) + $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0) begin
                    runs = $urandom_range(1, runs);
                end
            end else begin
                runs = $urandom_range(1, 6);
            end
            repeat (runs) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_item(MODE_SPARE, $urandom);
                end
                if ($urandom_range(0, 29) == 0) begin
                    send_item(MODE_LOAD, pick_value());
                    sent++;
                end
                if ($urandom_range(0, 39) == 0) begin
                    send_item(MODE_CLEAR, pick_value());
                    sent++;
                end
                send_item(MODE_NEXT, pick_value());
                sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(MODE_LOAD, pick_value());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        shadow_count = 0;
        restart_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles 30 percent, receiver stalls 68 percent
        test_empty_list();
        test_single_element();
        test_three_elements();
        test_full_list();
        test_random(160);
        drain_results();

        // roles swapped
        send_idle_pct = 68;
        recv_idle_pct = 30;
        test_random(160);
        drain_results();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(160);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
